>>> rtl/nwps_pkg.sv
// nwps_pkg: sizes, register index codes and shared types of the nibble wildcard scanner
// no dependencies; used by the interfaces, the window cell and the top level
`default_nettype none

package nwps_pkg;

	localparam int MAX_PATTERN_BYTES = 16;
	localparam int DISP_BYTES        = 4;
	localparam int WINDOW_DEPTH      = MAX_PATTERN_BYTES + DISP_BYTES;
	localparam int POSITION_BITS     = 32;
	localparam int ADDR_BITS         = 64;
	localparam int LEN_BITS          = 5;
	localparam int NEED_BITS         = $clog2(WINDOW_DEPTH + 1);
	localparam int PAT_IDX_BITS      = $clog2(MAX_PATTERN_BYTES);
	localparam int DISP_SUM_BITS     = 8 * DISP_BYTES + 2;
	localparam int CFG_INDEX_BITS    = 8;
	localparam int CFG_DATA_BITS     = 64;
	localparam int CARE_BITS         = 2 * MAX_PATTERN_BYTES;

	localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LOW    = 8'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_HIGH   = 8'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CARE_MASK      = 8'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LENGTH = 8'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_BASE     = 8'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_ADDRESS = 8'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RELATIVE_MODE  = 8'd6;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_ONLY     = 8'd7;

	typedef logic [7:0] byte_t;

	typedef struct packed {
		byte_t pattern;
		byte_t care;
		logic  in_use;
	} cell_ref_t;

endpackage

`default_nettype wire

>>> rtl/nwps_if.sv
// nwps_if: valid/ready channel interfaces of the scanner (bytes in, results out, register writes)
// depends on nwps_pkg
`default_nettype none

interface nwps_byte_if;
	import nwps_pkg::*;
	logic  valid;
	logic  ready;
	byte_t image_byte;
	logic  last_byte;
	modport source (output valid, output image_byte, output last_byte, input ready);
	modport sink (input valid, input image_byte, input last_byte, output ready);
endinterface

interface nwps_result_if;
	import nwps_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [ADDR_BITS-1:0] match_address;
	logic                 matched;
	logic                 scan_done;
	modport source (output valid, output match_address, output matched, output scan_done,
		input ready);
	modport sink (input valid, input match_address, input matched, input scan_done,
		output ready);
endinterface

interface nwps_cfg_if;
	import nwps_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [CFG_INDEX_BITS-1:0] index;
	logic [CFG_DATA_BITS-1:0]  data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/nibble_wildcard_pattern_scanner.sv
// nibble_wildcard_pattern_scanner: top level, register file, window cell row and result pipeline
// depends on nwps_pkg, nwps_if (channel interfaces) and nwps_cell
//
//   channel | dir | payload                               | transaction when
//   scan    | in  | image_byte, last_byte                 | scan.valid & scan.ready
//   result  | out | match_address, matched, scan_done     | result.valid & result.ready
//   cfg     | in  | index, data                           | cfg.valid & cfg.ready
//
// one byte per cycle while the result side does not block the output; each result passes through the stages below
// stages: window cell row and pattern compare, relative target add, output register
// each stage holds only while the stage after it is blocked, so bubbles are squeezed out
// cfg is always ready; reset clears control state and sets pattern_length to one
`default_nettype none

module nibble_wildcard_pattern_scanner (
	input  logic                 clk,
	input  logic                 arst_n,
	nwps_byte_if.sink            scan,
	nwps_result_if.source        result,
	nwps_cfg_if.sink             cfg
);
	import nwps_pkg::*;

	logic [63:0]                     pat_low_q;
	logic [63:0]                     pat_high_q;
	logic [CARE_BITS-1:0]            care_q;
	logic [LEN_BITS-1:0]             len_q;
	logic [ADDR_BITS-1:0]            base_q;
	logic [ADDR_BITS-1:0]            target_q;
	logic                            rel_q;
	logic                            first_q;

	logic [8*MAX_PATTERN_BYTES-1:0]  pat_all;
	logic [LEN_BITS-1:0]             len_eff;
	logic [NEED_BITS-1:0]            need;
	logic [NEED_BITS-1:0]            need_m1;
	logic [NEED_BITS-1:0]            first_cell;

	logic                            out_free;
	logic                            en_s2;
	logic                            en_s1;
	logic                            accept;

	logic [POSITION_BITS-1:0]        pos_q;
	logic                            v_s1;
	logic                            last_s1;
	logic [POSITION_BITS-1:0]        pos_s1;

	byte_t                           win [WINDOW_DEPTH];
	logic [WINDOW_DEPTH-1:0]         agree;
	logic                            pat_ok;
	logic                            pos_ok;
	logic [POSITION_BITS-1:0]        offset;
	logic [8*DISP_BYTES-1:0]         disp;
	logic [DISP_SUM_BITS-1:0]        dsum;

	logic                            v_s2;
	logic                            last_s2;
	logic                            cand_s2;
	logic [ADDR_BITS-1:0]            addr_s2;
	logic [DISP_SUM_BITS-1:0]        dsum_s2;
	logic                            rel_ok;
	logic                            hit;
	logic                            res;

	logic                            found_q;
	logic                            out_valid_q;
	logic [ADDR_BITS-1:0]            out_addr_q;
	logic                            out_matched_q;
	logic                            out_done_q;

	// register file
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			care_q     <= '0;
			len_q      <= LEN_BITS'(1);
			base_q     <= '0;
			target_q   <= '0;
			rel_q      <= 1'b0;
			first_q    <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_PATTERN_LOW:    pat_low_q  <= cfg.data;
				REG_PATTERN_HIGH:   pat_high_q <= cfg.data;
				REG_CARE_MASK:      care_q     <= cfg.data[CARE_BITS-1:0];
				REG_PATTERN_LENGTH: len_q      <= cfg.data[LEN_BITS-1:0];
				REG_IMAGE_BASE:     base_q     <= cfg.data;
				REG_TARGET_ADDRESS: target_q   <= cfg.data;
				REG_RELATIVE_MODE:  rel_q      <= cfg.data[0];
				REG_FIRST_ONLY:     first_q    <= cfg.data[0];
				default: ;
			endcase
		end
	end

	assign pat_all = {pat_high_q, pat_low_q};

	always_comb begin
		if (len_q == '0) begin
			len_eff = LEN_BITS'(1);
		end else if (len_q > LEN_BITS'(MAX_PATTERN_BYTES)) begin
			len_eff = LEN_BITS'(MAX_PATTERN_BYTES);
		end else begin
			len_eff = len_q;
		end
	end

	assign first_cell = rel_q ? NEED_BITS'(DISP_BYTES) : '0;
	assign need       = NEED_BITS'(len_eff) + first_cell;
	assign need_m1    = need - NEED_BITS'(1);

	// stage control
	assign out_free   = !out_valid_q || result.ready;
	assign en_s2      = !v_s2 || out_free;
	assign en_s1      = !v_s1 || en_s2;
	assign scan.ready = en_s1;
	assign accept     = scan.valid && en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= scan.valid;
			end
			if (accept) begin
				pos_q <= scan.last_byte ? '0 : pos_q + POSITION_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1 <= scan.last_byte;
			pos_s1  <= pos_q;
		end
	end

	// window cell row, newest byte in cell 0
	for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
		logic [NEED_BITS-1:0] pidx;
		logic [1:0]           cbits;
		cell_ref_t            cref;
		byte_t                feed;

		assign pidx  = need_m1 - NEED_BITS'(k);
		assign cbits = care_q[2*pidx[PAT_IDX_BITS-1:0] +: 2];
		assign cref.pattern = pat_all[8*pidx[PAT_IDX_BITS-1:0] +: 8];
		assign cref.care    = {{4{cbits[1]}}, {4{cbits[0]}}};
		assign cref.in_use  = (NEED_BITS'(k) <= need_m1) && (NEED_BITS'(k) >= first_cell);

		if (k == 0) begin : g_head
			assign feed = scan.image_byte;
		end else begin : g_link
			assign feed = win[k-1];
		end

		nwps_cell u_cell (
			.clk      (clk),
			.shift_en (accept),
			.byte_in  (feed),
			.cref     (cref),
			.byte_q   (win[k]),
			.agree    (agree[k])
		);
	end

	assign pat_ok = &agree;
	assign pos_ok = pos_s1 >= POSITION_BITS'(need_m1);
	assign offset = pos_s1 - POSITION_BITS'(need_m1);

	// little-endian displacement, oldest of the four newest bytes is the low byte
	for (genvar d = 0; d < DISP_BYTES; d++) begin : g_disp
		assign disp[8*d +: 8] = win[DISP_BYTES-1-d];
	end

	assign dsum = {{2{disp[8*DISP_BYTES-1]}}, disp} + DISP_SUM_BITS'(len_eff)
		+ DISP_SUM_BITS'(DISP_BYTES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			last_s2 <= last_s1;
			cand_s2 <= pat_ok && pos_ok;
			addr_s2 <= base_q + ADDR_BITS'(offset);
			dsum_s2 <= dsum;
		end
	end

	// relative target check and first-only filter
	assign rel_ok = (addr_s2 + {{(ADDR_BITS-DISP_SUM_BITS){dsum_s2[DISP_SUM_BITS-1]}}, dsum_s2})
		== target_q;
	assign hit = cand_s2 && (!rel_q || rel_ok) && !(first_q && found_q);
	assign res = v_s2 && (hit || last_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res;
			if (v_s2) begin
				if (last_s2) begin
					found_q <= 1'b0;
				end else if (hit) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res) begin
			out_addr_q    <= hit ? addr_s2 : '0;
			out_matched_q <= hit;
			out_done_q    <= last_s2;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.match_address = out_addr_q;
	assign result.matched       = out_matched_q;
	assign result.scan_done     = out_done_q;

	// checks
	a_result_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.matched || result.scan_done))
		else $error("result with neither match nor end of scan");

	a_no_address_without_match: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.matched) |-> (result.match_address == '0))
		else $error("match address set on a result without match");

	a_position_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && scan.last_byte) |=> (pos_q == '0))
		else $error("byte position not cleared after last byte");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!scan.ready |-> (v_s1 && v_s2 && out_valid_q))
		else $error("input stalled with a free stage");

endmodule

`default_nettype wire

>>> rtl/nwps_cell.sv
// nwps_cell: one byte of the sliding window, passed on to the next cell on each shift
// compares its byte with the pattern byte aligned to it; depends on nwps_pkg
`default_nettype none

module nwps_cell (
	input  logic               clk,
	input  logic               shift_en,
	input  nwps_pkg::byte_t    byte_in,
	input  nwps_pkg::cell_ref_t cref,
	output nwps_pkg::byte_t    byte_q,
	output logic               agree
);
	import nwps_pkg::*;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= byte_in;
		end
	end

	// unused cells and wildcard nibbles always agree
	assign agree = !cref.in_use || (((byte_q ^ cref.pattern) & cref.care) == '0);

endmodule

`default_nettype wire

>>> bench/nibble_wildcard_pattern_scanner_tb.sv
// nibble_wildcard_pattern_scanner_tb: self-checking bench for the nibble wildcard byte scanner
// streams planted and random images under many register settings and checks every result
// against a behavioral window model; depends on nwps_pkg, nwps_if and the scanner rtl
`default_nettype none

module nibble_wildcard_pattern_scanner_tb;
	import nwps_pkg::*;

	typedef struct packed {
		logic [ADDR_BITS-1:0] match_address;
		logic                 matched;
		logic                 scan_done;
	} scan_result_t;

	class signature_scoreboard;
		logic [63:0]              pat_low, pat_high;
		logic [CARE_BITS-1:0]     care_mask;
		logic [LEN_BITS-1:0]      pat_len;
		logic [ADDR_BITS-1:0]     base, target;
		logic                     rel_mode, first_only;
		byte_t                    window [WINDOW_DEPTH];
		logic [POSITION_BITS-1:0] position;
		logic                     found;
		scan_result_t             expected_results[$];
		int                       errors, checked, hits, scans;

		function new();
			pat_low    = '0;
			pat_high   = '0;
			care_mask  = '0;
			pat_len    = 1;
			base       = '0;
			target     = '0;
			rel_mode   = 1'b0;
			first_only = 1'b0;
			errors     = 0;
			checked    = 0;
			hits       = 0;
			scans      = 0;
			clear_scan();
		endfunction

		function void clear_scan();
			foreach (window[i])
				window[i] = '0;
			position = '0;
			found    = 1'b0;
		endfunction

		function int eff_len();
			if (pat_len == 0)
				return 1;
			if (pat_len > MAX_PATTERN_BYTES)
				return MAX_PATTERN_BYTES;
			return int'(pat_len);
		endfunction

		function byte_t pat_byte(int i);
			return (i < 8) ? pat_low[8*(i%8) +: 8] : pat_high[8*(i%8) +: 8];
		endfunction

		function byte_t care_byte(int i);
			logic [1:0] bits;
			bits = care_mask[2*i +: 2];
			return {{4{bits[1]}}, {4{bits[0]}}};
		endfunction

		function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
			case (idx)
				REG_PATTERN_LOW:    pat_low = data;
				REG_PATTERN_HIGH:   pat_high = data;
				REG_CARE_MASK:      care_mask = data[CARE_BITS-1:0];
				REG_PATTERN_LENGTH: pat_len = data[LEN_BITS-1:0];
				REG_IMAGE_BASE:     base = data;
				REG_TARGET_ADDRESS: target = data;
				REG_RELATIVE_MODE:  rel_mode = data[0];
				REG_FIRST_ONLY:     first_only = data[0];
				default: ;
			endcase
		endfunction

		// shift the byte in, look for a pattern ending here, queue the result it causes
		function void note_byte(byte_t b, logic last);
			int                   len, need, i;
			logic                 ok, hit;
			logic [ADDR_BITS-1:0] addr, disp;
			scan_result_t         r;
			len  = eff_len();
			need = len + (rel_mode ? DISP_BYTES : 0);
			for (i = WINDOW_DEPTH - 1; i > 0; i--)
				window[i] = window[i-1];
			window[0] = b;
			hit  = 1'b0;
			addr = '0;
			if (position >= POSITION_BITS'(need - 1) && !(first_only && found)) begin
				ok = 1'b1;
				for (i = 0; i < len; i++)
					if ((window[need-1-i] & care_byte(i)) != (pat_byte(i) & care_byte(i)))
						ok = 1'b0;
				addr = base + ADDR_BITS'(position) - ADDR_BITS'(need - 1);
				if (ok && rel_mode) begin
					disp = {{(ADDR_BITS-32){window[0][7]}}, window[0], window[1], window[2],
						window[3]};
					ok = (addr + ADDR_BITS'(len) + disp + ADDR_BITS'(DISP_BYTES)) == target;
				end
				if (ok) begin
					hit   = 1'b1;
					found = 1'b1;
				end
			end
			if (last)
				clear_scan();
			else
				position++;
			if (hit || last) begin
				r.match_address = hit ? addr : '0;
				r.matched       = hit;
				r.scan_done     = last;
				expected_results = {expected_results, r};
			end
		endfunction

		task report(string what);
			errors++;
			if (errors <= 100)
				$display("mismatch %0d: %s", errors, what);
		endtask

		task check_result(logic [ADDR_BITS-1:0] addr, logic matched, logic done);
			scan_result_t want;
			if (expected_results.size() == 0) begin
				report($sformatf("unexpected result addr %h matched %b done %b", addr, matched,
					done));
				return;
			end
			want = expected_results.pop_front();
			checked++;
			if (matched)
				hits++;
			if (done)
				scans++;
			if (addr !== want.match_address)
				report($sformatf("match_address %h, want %h", addr, want.match_address));
			if (matched !== want.matched)
				report($sformatf("matched %b, want %b (addr %h)", matched, want.matched,
					want.match_address));
			if (done !== want.scan_done)
				report($sformatf("scan_done %b, want %b", done, want.scan_done));
		endtask
	endclass

	localparam int DRAIN_CYCLES   = 10;
	localparam int LONG_HOLD      = 150;
	localparam int TIMEOUT_CYCLES = 1_000_000;
	localparam int RANDOM_END     = 1220;
	localparam int TOTAL_BYTES    = 1420;

	localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED_LOW = REG_FIRST_ONLY + 1'b1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED_TOP = '1;

	logic clk = 1'b0;
	logic arst_n;

	nwps_byte_if   scan_ch ();
	nwps_result_if res_ch ();
	nwps_cfg_if    cfg_ch ();

	signature_scoreboard sb;
	bit                  send_gaps, recv_stalls, hold_request;
	int                  bytes_sent, long_holds, settings_applied;

	nibble_wildcard_pattern_scanner u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.scan   (scan_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (scan_ch.valid && scan_ch.ready)
			sb.note_byte(scan_ch.image_byte, scan_ch.last_byte);
		if (res_ch.valid && res_ch.ready)
			sb.check_result(res_ch.match_address, res_ch.matched, res_ch.scan_done);
	end

	// result side back-pressure, with one long hold on request
	initial begin
		res_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_request) begin
				res_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_request = 1'b0;
				long_holds++;
			end else if (recv_stalls && $urandom_range(0, 5) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				res_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic send_byte(byte_t b, logic last);
		if (send_gaps && $urandom_range(0, 7) == 0) begin
			scan_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		scan_ch.valid      <= 1'b1;
		scan_ch.image_byte <= b;
		scan_ch.last_byte  <= last;
		do @(posedge clk); while (!scan_ch.ready);
		bytes_sent++;
	endtask

	task automatic run_image(input byte_t img[$]);
		foreach (img[i])
			send_byte(img[i], i == img.size() - 1);
	endtask

	task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.write_reg(idx, data);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_settings(logic [63:0] pl, logic [63:0] ph, logic [31:0] cm,
		logic [4:0] len, logic [63:0] b, logic [63:0] t, logic rel, logic first);
		write_reg(REG_PATTERN_LOW, pl);
		write_reg(REG_PATTERN_HIGH, ph);
		write_reg(REG_CARE_MASK, 64'(cm));
		write_reg(REG_PATTERN_LENGTH, 64'(len));
		write_reg(REG_IMAGE_BASE, b);
		write_reg(REG_TARGET_ADDRESS, t);
		write_reg(REG_RELATIVE_MODE, 64'(rel));
		write_reg(REG_FIRST_ONLY, 64'(first));
		settings_applied++;
	endtask

	// stop sending, all results in, then room for bytes that cause none
	task automatic settle();
		scan_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_settings();
		logic [63:0] pl, ph, b, t;
		logic [31:0] cm, r;
		logic [4:0]  len;
		logic        rel, first;
		int          sel;
		pl = {$urandom, $urandom};
		ph = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: begin
				pl = '1;
				ph = '1;
			end
			1: begin
				pl = '0;
				ph = '0;
			end
			default: ;
		endcase
		case ($urandom_range(0, 4))
			0: cm = '1;
			1: cm = '0;
			2: cm = $urandom;
			default: cm = $urandom | $urandom;
		endcase
		sel = $urandom_range(0, 9);
		if (sel < 6)
			len = 5'($urandom_range(1, 6));
		else if (sel < 8)
			len = 5'($urandom_range(7, 16));
		else if (sel == 8)
			len = 5'($urandom_range(17, 31));
		else
			len = $urandom_range(0, 1) ? 5'd0 : 5'd16;
		rel   = $urandom_range(0, 2) == 0;
		first = $urandom_range(0, 2) == 0;
		case ($urandom_range(0, 4))
			0: b = '0;
			1: b = '1;
			2: b = 64'hFFFF_FFFF_FFFF_FF00 | 64'($urandom_range(0, 255));
			default: b = {$urandom, $urandom};
		endcase
		r = $urandom;
		if (rel && $urandom_range(0, 3) != 0)
			t = b + {{32{r[31]}}, r};
		else if ($urandom_range(0, 2) == 0)
			t = $urandom_range(0, 1) ? 64'h0 : '1;
		else
			t = {$urandom, r};
		apply_settings(pl, ph, cm, len, b, t, rel, first);
	endtask

	// random image with pattern instances planted, some of them damaged
	task automatic random_scan();
		byte_t                img[$];
		int                   n, need, len, o, i, k;
		logic [ADDR_BITS-1:0] d;
		byte_t                m;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
		for (i = 0; i < n; i++)
			img = {img, byte_t'($urandom)};
		len  = sb.eff_len();
		need = len + (sb.rel_mode ? DISP_BYTES : 0);
		if (n >= need) repeat ($urandom_range(0, 3)) begin
			o = $urandom_range(0, n - need);
			for (i = 0; i < len; i++) begin
				m = sb.care_byte(i);
				img[o+i] = (sb.pat_byte(i) & m) | (byte_t'($urandom) & ~m);
			end
			if (sb.rel_mode) begin
				d = sb.target - (sb.base + ADDR_BITS'(o + len + DISP_BYTES));
				for (k = 0; k < DISP_BYTES; k++)
					img[o+len+k] = d[8*k +: 8];
			end
			if ($urandom_range(0, 5) == 0) begin
				k = $urandom_range(0, need - 1);
				img[o+k] = img[o+k] ^ (8'h01 << $urandom_range(0, 7));
			end
		end
		run_image(img);
	endtask

	task automatic random_phase(int until_bytes);
		int phase_end;
		random_settings();
		phase_end = bytes_sent + $urandom_range(50, 120);
		if (phase_end > until_bytes)
			phase_end = until_bytes;
		while (bytes_sent < phase_end)
			random_scan();
		settle();
	endtask

	initial begin
		byte_t       img_bytes[$];
		logic [63:0] rel_base;
		scan_ch.valid      <= 1'b0;
		scan_ch.image_byte <= '0;
		scan_ch.last_byte  <= 1'b0;
		cfg_ch.valid       <= 1'b0;
		cfg_ch.index       <= '0;
		cfg_ch.data        <= '0;
		arst_n             <= 1'b0;
		send_gaps        = 1'b1;
		recv_stalls      = 1'b1;
		hold_request     = 1'b0;
		bytes_sent       = 0;
		long_holds       = 0;
		settings_applied = 0;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset values: every byte is a one-byte wildcard hit
		img_bytes = '{8'h00, 8'hFF, 8'h5A};
		run_image(img_bytes);
		settle();

		// length zero acts as one, high nibble only, first hit only, unmapped writes ignored
		apply_settings(64'hFFFF_FFFF_FFFF_FFA5, 64'h0, 32'h0000_0002, 5'd0, 64'h0, 64'h0,
			1'b0, 1'b1);
		write_reg(REG_UNMAPPED_LOW, '1);
		write_reg(REG_UNMAPPED_TOP, '1);
		img_bytes = '{8'hA0, 8'hAF, 8'h15};
		run_image(img_bytes);
		settle();

		// oversize length clamps to sixteen; image too short to hold it
		apply_settings('1, '1, '1, 5'd31, '1, '1, 1'b0, 1'b0);
		img_bytes = '{8'hFF, 8'hFF, 8'hFF};
		run_image(img_bytes);
		settle();

		// relative reference, largest positive then most negative displacement, address wrap
		rel_base = 64'hFFFF_FFFF_FFFF_FFFE;
		apply_settings(64'hE8, 64'h0, 32'h3, 5'd1, rel_base, rel_base + 64'd5 + 64'h7FFF_FFFF,
			1'b1, 1'b0);
		img_bytes = '{8'hE8, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
		run_image(img_bytes);
		settle();
		write_reg(REG_TARGET_ADDRESS, rel_base + 64'd5 - 64'h8000_0000);
		img_bytes = '{8'hE8, 8'h00, 8'h00, 8'h00, 8'h80};
		run_image(img_bytes);
		img_bytes = '{8'hE8, 8'h00, 8'h00};
		run_image(img_bytes);
		settle();

		// output held off while every byte matches, so the input has to stall
		apply_settings({$urandom, $urandom}, {$urandom, $urandom}, 32'h0, 5'd1,
			{$urandom, $urandom}, {$urandom, $urandom}, 1'b0, 1'b0);
		send_gaps    = 1'b0;
		recv_stalls  = 1'b0;
		hold_request = 1'b1;
		img_bytes.delete();
		repeat (120)
			img_bytes = {img_bytes, byte_t'($urandom)};
		run_image(img_bytes);
		settle();
		send_gaps   = 1'b1;
		recv_stalls = 1'b1;

		while (bytes_sent < RANDOM_END)
			random_phase(RANDOM_END);

		// closing stretch at full rate on both sides
		send_gaps   = 1'b0;
		recv_stalls = 1'b0;
		while (bytes_sent < TOTAL_BYTES)
			random_phase(TOTAL_BYTES);
		settle();

		$display("run covered %0d bytes over %0d register settings, %0d long output holds",
			bytes_sent, settings_applied, long_holds);
		$display("results checked %0d: %0d pattern hits, %0d completed scans",
			sb.checked, sb.hits, sb.scans);
		if (sb.errors == 0) begin
			$display("nibble_wildcard_pattern_scanner_tb: PASS");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("nibble_wildcard_pattern_scanner_tb: FAIL");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT_CYCLES * 10);
		$display("timeout with %0d results outstanding", sb.expected_results.size());
		$display("nibble_wildcard_pattern_scanner_tb: FAIL");
		$finish;
	end

endmodule

`default_nettype wire

>>> filelist.f
rtl/nwps_pkg.sv
rtl/nwps_if.sv
rtl/nwps_cell.sv
rtl/nibble_wildcard_pattern_scanner.sv
bench/nibble_wildcard_pattern_scanner_tb.sv
